@@ rtl/trrs_pkg.sv @@
// shared constants, types and the arctangent table for the two-link arm step block
// no dependencies
`default_nettype none

package trrs_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_COUNT    = 24;
    localparam int ITER_W        = $clog2(ATAN_COUNT);

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [31:0]        TURN_FRAC   = 32'd2670177;

    // square root of the squared error
    localparam int RAD_W  = 44;
    localparam int ROOT_W = RAD_W / 2;
    localparam int RCNT_W = $clog2(ROOT_W);

    // ratio division
    localparam int NUM_W  = 56;
    localparam int DET_W  = 38;
    localparam int QUO_W  = NUM_W - 1;
    localparam int DEN_W  = DET_W - 1;
    localparam int QCNT_W = $clog2(QUO_W);

    typedef logic [ANGLE_BITS-1:0] angle_t;

    typedef enum logic [1:0] {
        ST_STEPPED  = 2'd0,
        ST_REACHED  = 2'd1,
        ST_SINGULAR = 2'd2,
        ST_LOADED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_LINK_ONE = 3'd0,
        REG_LINK_TWO = 3'd1,
        REG_TARGET_X = 3'd2,
        REG_TARGET_Y = 3'd3,
        REG_GAIN     = 3'd4,
        REG_DT       = 3'd5,
        REG_REACH    = 3'd6,
        REG_DET_MIN  = 3'd7
    } cfg_addr_t;

    function automatic logic signed [31:0] atan_at(input logic [ITER_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/trrs_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle, sin and cos in q.30
// depends on trrs_pkg
`default_nettype none

module trrs_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire trrs_pkg::angle_t   angle,
    output logic                    done,
    output logic signed [31:0]      sin_q,
    output logic signed [31:0]      cos_q
);

    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [trrs_pkg::ITER_W-1:0] i_reg;
    logic flip_reg, busy_reg, done_reg;

    logic [31:0] u0, u0q, u1;
    logic flip;

    assign u0   = {angle, {(32 - trrs_pkg::ANGLE_BITS){1'b0}}};
    assign u0q  = u0 + 32'h4000_0000;
    assign flip = u0q[31];
    assign u1   = flip ? (u0 + 32'h8000_0000) : u0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         i_reg == trrs_pkg::ITER_W'(trrs_pkg::CORDIC_STAGES - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= trrs_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= signed'(u1);
            i_reg    <= '0;
            flip_reg <= flip;
        end else if (busy_reg) begin
            if (!z_reg[31]) begin
                x_reg <= x_reg - (y_reg >>> i_reg);
                y_reg <= y_reg + (x_reg >>> i_reg);
                z_reg <= z_reg - trrs_pkg::atan_at(i_reg);
            end else begin
                x_reg <= x_reg + (y_reg >>> i_reg);
                y_reg <= y_reg - (x_reg >>> i_reg);
                z_reg <= z_reg + trrs_pkg::atan_at(i_reg);
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    assign done  = done_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;
    assign cos_q = flip_reg ? -x_reg : x_reg;

endmodule

`default_nettype wire

@@ rtl/trrs_root.sv @@
// iterative integer square root, one result bit per cycle
// depends on trrs_pkg
`default_nettype none

module trrs_root (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [trrs_pkg::RAD_W-1:0]   radicand,
    output logic                              done,
    output logic [trrs_pkg::ROOT_W-1:0]       root
);

    localparam int REM_W = trrs_pkg::ROOT_W + 3;

    logic [trrs_pkg::RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [trrs_pkg::ROOT_W-1:0] root_reg;
    logic [trrs_pkg::RCNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;

    logic [REM_W+1:0] rem_sh, trial;
    logic ge;

    assign rem_sh = {rem_reg, rad_reg[trrs_pkg::RAD_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == trrs_pkg::RCNT_W'(trrs_pkg::ROOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[trrs_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[trrs_pkg::ROOT_W-2:0], ge};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/trrs_divider.sv @@
// signed restoring divider, quotient truncated toward zero, one bit per cycle
// depends on trrs_pkg
`default_nettype none

module trrs_divider (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic signed [trrs_pkg::NUM_W-1:0]  num,
    input  wire logic signed [trrs_pkg::DET_W-1:0]  den,
    output logic                                    done,
    output logic signed [trrs_pkg::QUO_W:0]         quot
);

    localparam int QW = trrs_pkg::QUO_W;
    localparam int DW = trrs_pkg::DEN_W;

    logic [QW-1:0] quo_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [trrs_pkg::QCNT_W-1:0] cnt_reg;
    logic neg_reg, busy_reg, done_reg;

    logic [DW:0] rem_sh;
    logic ge;

    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == trrs_pkg::QCNT_W'(QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num[trrs_pkg::NUM_W-1] ? QW'(-num) : QW'(num);
            den_reg <= den[trrs_pkg::DET_W-1] ? DW'(-den) : DW'(den);
            rem_reg <= '0;
            neg_reg <= num[trrs_pkg::NUM_W-1] ^ den[trrs_pkg::DET_W-1];
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});

endmodule

`default_nettype wire

@@ rtl/two_link_arm_resolved_rate_step.sv @@
// top level of the two-link arm resolved-rate step block: sequencer, shared multiplier,
// apb registers and stream ports; depends on trrs_pkg, trrs_cordic, trrs_root, trrs_divider
//
// A load transaction (s_tuser = 0) sets both joint angles and goes straight to the done
// state, which loads its result into the output register once that is free. A step
// transaction (s_tuser = 1) runs one resolved-rate iteration: two passes of the shared
// cordic, passes of the one 33x33 multiplier (twenty when the arm moves), a square root
// and, when the arm actually moves, two divisions. Reached and singular results skip the
// divisions. One transaction is worked on at a time; the result sits in an output
// register, so the next transaction is taken while it waits.
`default_nettype none

module two_link_arm_resolved_rate_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // load_angle_one, load_angle_two
    input  wire logic [0:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // angle_one, angle_two, pos_x, pos_y, error_distance
    output logic [1:0]       m_tuser    // status
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CS1   = 9'b000000010,
        ST_CS2   = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_MACC  = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_CHECK = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef enum logic [4:0] {
        MOP_L1C1, MOP_L2C12, MOP_L1S1, MOP_L2S12, MOP_EXX, MOP_EYY,
        MOP_DET1, MOP_DET2, MOP_GT, MOP_GTK, MOP_N1A, MOP_N1B,
        MOP_R1LL, MOP_R1LH, MOP_R1HL, MOP_N2A, MOP_N2B,
        MOP_R2LL, MOP_R2LH, MOP_R2HL
    } mop_t;

    localparam int AB = trrs_pkg::ANGLE_BITS;

    state_t state_reg, state_next;
    mop_t   mop_reg, mop_next;

    // configuration
    logic [15:0]        l1_reg, l2_reg, gain_reg, dt_reg, detmin_reg;
    logic signed [19:0] tx_reg, ty_reg;
    logic [18:0]        reach_reg;

    trrs_pkg::angle_t angle1_reg, angle2_reg;

    logic signed [31:0] s1_reg, c1_reg, s12_reg, c12_reg;
    logic signed [65:0] prod_reg, acc_reg;
    logic signed [19:0] px_reg, py_reg, jd_reg, jb_reg;
    logic [trrs_pkg::ROOT_W-1:0] dist_reg;
    logic signed [trrs_pkg::DET_W-1:0] det_reg;
    logic [63:0] k_reg, ratio_reg;
    trrs_pkg::status_t status_reg;

    logic        m_valid_reg;
    logic [95:0] m_data_reg;
    logic [1:0]  m_user_reg;

    // unit handshakes
    logic cordic_start, cordic_done, root_start, root_done, div_start, div_done;
    trrs_pkg::angle_t cordic_angle;
    logic signed [31:0] sin_q, cos_q;
    logic [trrs_pkg::ROOT_W-1:0] root;
    logic signed [trrs_pkg::QUO_W:0] quot;

    logic signed [20:0] ex, ey, ja, jc;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] sum_add, sum_sub, rnd_sum, rnd_prod;
    logic [63:0] p_mix, p_round;
    trrs_pkg::angle_t step;
    logic signed [trrs_pkg::NUM_W-1:0] div_num;
    logic [trrs_pkg::DET_W-1:0] det_mag;
    logic reached, singular, out_load, cfg_wr, accept;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign ex = 21'(tx_reg) - 21'(px_reg);
    assign ey = 21'(ty_reg) - 21'(py_reg);
    assign ja = -(21'(py_reg));
    assign jc = 21'(px_reg);

    assign sum_add  = acc_reg + prod_reg;
    assign sum_sub  = acc_reg - prod_reg;
    assign rnd_sum  = sum_add + 66'sd536870912;
    assign rnd_prod = prod_reg + 66'sd536870912;
    assign p_mix    = acc_reg[63:0] + {prod_reg[31:0], 32'd0};
    assign p_round  = p_mix + (64'd1 << (63 - AB));
    assign step     = p_round[63 -: AB];
    assign div_num  = {sum_sub[39:0], 16'd0};

    assign det_mag  = det_reg[trrs_pkg::DET_W-1] ? trrs_pkg::DET_W'(-det_reg)
                                                 : trrs_pkg::DET_W'(det_reg);
    assign reached  = dist_reg < trrs_pkg::ROOT_W'(reach_reg);
    assign singular = (det_reg == '0) || (det_mag < trrs_pkg::DET_W'(detmin_reg));

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mop_reg)
            MOP_L1C1:  begin mul_a = 33'(l1_reg); mul_b = 33'(c1_reg);  end
            MOP_L2C12: begin mul_a = 33'(l2_reg); mul_b = 33'(c12_reg); end
            MOP_L1S1:  begin mul_a = 33'(l1_reg); mul_b = 33'(s1_reg);  end
            MOP_L2S12: begin mul_a = 33'(l2_reg); mul_b = 33'(s12_reg); end
            MOP_EXX:   begin mul_a = 33'(ex);     mul_b = 33'(ex);      end
            MOP_EYY:   begin mul_a = 33'(ey);     mul_b = 33'(ey);      end
            MOP_DET1:  begin mul_a = 33'(ja);     mul_b = 33'(jd_reg);  end
            MOP_DET2:  begin mul_a = 33'(jb_reg); mul_b = 33'(jc);      end
            MOP_GT:    begin mul_a = 33'(gain_reg); mul_b = 33'(dt_reg); end
            MOP_GTK: begin
                mul_a = {1'b0, k_reg[31:0]};
                mul_b = {1'b0, trrs_pkg::TURN_FRAC};
            end
            MOP_N1A:   begin mul_a = 33'(jd_reg); mul_b = 33'(ex); end
            MOP_N1B:   begin mul_a = 33'(jb_reg); mul_b = 33'(ey); end
            MOP_N2A:   begin mul_a = 33'(ja);     mul_b = 33'(ey); end
            MOP_N2B:   begin mul_a = 33'(jc);     mul_b = 33'(ex); end
            MOP_R1LL, MOP_R2LL: begin
                mul_a = {1'b0, ratio_reg[31:0]};
                mul_b = {1'b0, k_reg[31:0]};
            end
            MOP_R1LH, MOP_R2LH: begin
                mul_a = {1'b0, ratio_reg[31:0]};
                mul_b = {1'b0, k_reg[63:32]};
            end
            MOP_R1HL, MOP_R2HL: begin
                mul_a = {1'b0, ratio_reg[63:32]};
                mul_b = {1'b0, k_reg[31:0]};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mop_next     = mop_reg;
        cordic_start = 1'b0;
        cordic_angle = angle1_reg;
        root_start   = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        cordic_start = 1'b1;
                        state_next   = ST_CS1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CS1: begin
                cordic_angle = trrs_pkg::angle_t'(angle1_reg + angle2_reg);
                if (cordic_done) begin
                    cordic_start = 1'b1;
                    state_next   = ST_CS2;
                end
            end
            ST_CS2: begin
                if (cordic_done) begin
                    mop_next   = MOP_L1C1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_MACC;
            ST_MACC: begin
                mop_next   = mop_t'(mop_reg + 1'b1);
                state_next = ST_MUL;
                case (mop_reg)
                    MOP_EYY: begin
                        root_start = 1'b1;
                        state_next = ST_SQRT;
                    end
                    MOP_DET2: state_next = ST_CHECK;
                    MOP_N1B, MOP_N2B: begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    MOP_R2HL: state_next = ST_DONE;
                    default: state_next = ST_MUL;
                endcase
            end
            ST_SQRT: if (root_done) state_next = ST_MUL;
            ST_CHECK: state_next = (reached || singular) ? ST_DONE : ST_MUL;
            ST_DIV: if (div_done) state_next = ST_MUL;
            ST_DONE: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mop_reg     <= MOP_L1C1;
            m_valid_reg <= 1'b0;
            angle1_reg  <= '0;
            angle2_reg  <= '0;
            l1_reg      <= 16'd4096;
            l2_reg      <= 16'd4096;
            tx_reg      <= '0;
            ty_reg      <= '0;
            gain_reg    <= 16'd256;
            dt_reg      <= 16'd655;
            reach_reg   <= 19'd4;
            detmin_reg  <= 16'd17;
        end else begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && !s_tuser[0]) begin
                angle1_reg <= trrs_pkg::angle_t'(s_tdata[15:0]);
                angle2_reg <= trrs_pkg::angle_t'(s_tdata[31:16]);
            end else if (state_reg == ST_MACC && mop_reg == MOP_R1HL) begin
                angle1_reg <= trrs_pkg::angle_t'(angle1_reg + step);
            end else if (state_reg == ST_MACC && mop_reg == MOP_R2HL) begin
                angle2_reg <= trrs_pkg::angle_t'(angle2_reg + step);
            end
            if (cfg_wr) begin
                unique case (trrs_pkg::cfg_addr_t'(paddr[4:2]))
                    trrs_pkg::REG_LINK_ONE: l1_reg     <= pwdata[15:0];
                    trrs_pkg::REG_LINK_TWO: l2_reg     <= pwdata[15:0];
                    trrs_pkg::REG_TARGET_X: tx_reg     <= signed'(pwdata[19:0]);
                    trrs_pkg::REG_TARGET_Y: ty_reg     <= signed'(pwdata[19:0]);
                    trrs_pkg::REG_GAIN:     gain_reg   <= pwdata[15:0];
                    trrs_pkg::REG_DT:       dt_reg     <= pwdata[15:0];
                    trrs_pkg::REG_REACH:    reach_reg  <= pwdata[18:0];
                    trrs_pkg::REG_DET_MIN:  detmin_reg <= pwdata[15:0];
                endcase
            end
        end
    end

    always_comb begin
        unique case (trrs_pkg::cfg_addr_t'(paddr[4:2]))
            trrs_pkg::REG_LINK_ONE: prdata = 32'(l1_reg);
            trrs_pkg::REG_LINK_TWO: prdata = 32'(l2_reg);
            trrs_pkg::REG_TARGET_X: prdata = 32'(unsigned'(tx_reg));
            trrs_pkg::REG_TARGET_Y: prdata = 32'(unsigned'(ty_reg));
            trrs_pkg::REG_GAIN:     prdata = 32'(gain_reg);
            trrs_pkg::REG_DT:       prdata = 32'(dt_reg);
            trrs_pkg::REG_REACH:    prdata = 32'(reach_reg);
            trrs_pkg::REG_DET_MIN:  prdata = 32'(detmin_reg);
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept && !s_tuser[0]) begin
            px_reg     <= '0;
            py_reg     <= '0;
            dist_reg   <= '0;
            status_reg <= trrs_pkg::ST_LOADED;
        end
        if (state_reg == ST_CS1 && cordic_done) begin
            s1_reg <= sin_q;
            c1_reg <= cos_q;
        end
        if (state_reg == ST_CS2 && cordic_done) begin
            s12_reg <= sin_q;
            c12_reg <= cos_q;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_MACC) begin
            case (mop_reg)
                MOP_L1C1, MOP_L1S1, MOP_EXX, MOP_DET1, MOP_N1A, MOP_N2A,
                MOP_R1LL, MOP_R2LL: acc_reg <= prod_reg;
                MOP_L2C12: begin
                    px_reg <= rnd_sum[49:30];
                    jd_reg <= rnd_prod[49:30];
                end
                MOP_L2S12: begin
                    py_reg <= rnd_sum[49:30];
                    jb_reg <= -rnd_prod[49:30];
                end
                MOP_DET2: det_reg <= sum_sub[trrs_pkg::DET_W-1:0];
                MOP_GT:   k_reg   <= 64'(prod_reg[31:0]);
                MOP_GTK:  k_reg   <= prod_reg[63:0];
                MOP_R1LH, MOP_R2LH: acc_reg <= signed'(66'(p_mix));
                default: acc_reg <= acc_reg;
            endcase
        end
        if (state_reg == ST_SQRT && root_done) begin
            dist_reg <= root;
        end
        if (state_reg == ST_CHECK) begin
            status_reg <= reached  ? trrs_pkg::ST_REACHED :
                          singular ? trrs_pkg::ST_SINGULAR : trrs_pkg::ST_STEPPED;
        end
        if (state_reg == ST_DIV && div_done) begin
            ratio_reg <= 64'(quot);
        end
        if (out_load) begin
            m_data_reg <= {4'd0,
                           (dist_reg > trrs_pkg::ROOT_W'(20'hFFFFF)) ? 20'hFFFFF : dist_reg[19:0],
                           py_reg, px_reg, 16'(angle2_reg), 16'(angle1_reg)};
            m_user_reg <= status_reg;
        end
    end

    trrs_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_q   (sin_q),
        .cos_q   (cos_q)
    );

    trrs_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (sum_add[trrs_pkg::RAD_W-1:0]),
        .done     (root_done),
        .root     (root)
    );

    trrs_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (det_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_load_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0]) |=> (state_reg == ST_DONE))
        else $error("load transaction did not go straight to result");

    a_cordic_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_CS1 || state_reg == ST_CS2))
        else $error("cordic finished outside its states");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_loaded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == trrs_pkg::ST_LOADED) |-> (m_tdata[91:32] == '0))
        else $error("load result carries nonzero position or error");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for two_link_arm_resolved_rate_step: stream driver, stream monitor,
// apb register writes and a bit-true predictor of one resolved-rate step
// depends on trrs_pkg and the rtl of the block
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic        action;
        logic [15:0] ang_one;
        logic [15:0] ang_two;
    } arm_cmd_t;

    typedef struct packed {
        logic [15:0] ang_one;
        logic [15:0] ang_two;
        logic [19:0] pos_x;
        logic [19:0] pos_y;
        logic [19:0] err_dist;
        logic [1:0]  status;
    } arm_result_t;

    localparam longint ATAN_TAB [16] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // load_angle_one, load_angle_two
    logic [0:0]  s_tuser = '0;   // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // angle_one, angle_two, pos_x, pos_y, error_distance
    logic [1:0]  m_tuser;        // status

    two_link_arm_resolved_rate_step u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor copy of the registers and joint angles
    logic [15:0] link_one = 16'd4096, link_two = 16'd4096;
    logic [19:0] tgt_x = '0, tgt_y = '0;
    logic [15:0] gain = 16'd256, dt = 16'd655;
    logic [18:0] reach = 19'd4;
    logic [15:0] det_min = 16'd17;
    logic [15:0] joint_one = '0, joint_two = '0;

    arm_cmd_t    pending_cmds[$];
    arm_result_t expected_results[$];
    int send_idle = 13, recv_idle = 71;
    int errors = 0, cycles = 0;
    int n_loaded = 0, n_stepped = 0, n_reached = 0, n_singular = 0;

    function automatic longint round_q30(longint v);
        return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    task automatic cordic_sincos(input logic [15:0] a, output longint s, output longint c);
        logic [31:0] u;
        logic        flip;
        longint      x, y, z, dx, dy;
        u = {a, 16'h0000};
        flip = u[31] ^ u[30];
        if (flip) u = u + 32'h80000000;
        z = longint'($signed(u));
        x = trrs_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] joint_increment(longint ratio);
        logic [63:0] p;
        p = 64'(ratio) * {48'd0, gain} * {48'd0, dt} * 64'(trrs_pkg::TURN_FRAC);
        p = p + (64'd1 << 47);
        return p[63:48];
    endfunction

    task automatic predict_step(input arm_cmd_t cmd);
        arm_result_t r;
        longint s1, c1, s12, c12, px, py, ex, ey, ja, jb, jc, jd, det, mag, n1, n2;
        longint l1, l2;
        logic [63:0] err_root;
        r = '0;
        if (!cmd.action) begin
            joint_one = cmd.ang_one;
            joint_two = cmd.ang_two;
            r.status = trrs_pkg::ST_LOADED;
            n_loaded++;
        end else begin
            l1 = longint'(link_one);
            l2 = longint'(link_two);
            cordic_sincos(joint_one, s1, c1);
            cordic_sincos(joint_one + joint_two, s12, c12);
            px = round_q30(l1 * c1 + l2 * c12);
            py = round_q30(l1 * s1 + l2 * s12);
            jd = round_q30(l2 * c12);
            jb = -round_q30(l2 * s12);
            jc = px;
            ja = -py;
            ex = longint'($signed(tgt_x)) - px;
            ey = longint'($signed(tgt_y)) - py;
            err_root = int_sqrt(64'(ex * ex) + 64'(ey * ey));
            r.err_dist = (err_root > 64'd1048575) ? 20'hFFFFF : err_root[19:0];
            r.pos_x = px[19:0];
            r.pos_y = py[19:0];
            det = ja * jd - jb * jc;
            mag = det < 0 ? -det : det;
            if (err_root < 64'(reach)) begin
                r.status = trrs_pkg::ST_REACHED;
                n_reached++;
            end else if (det == 0 || mag < longint'(det_min)) begin
                r.status = trrs_pkg::ST_SINGULAR;
                n_singular++;
            end else begin
                n1 = jd * ex - jb * ey;
                n2 = ja * ey - jc * ex;
                joint_one = joint_one + joint_increment((n1 * 65536) / det);
                joint_two = joint_two + joint_increment((n2 * 65536) / det);
                r.status = trrs_pkg::ST_STEPPED;
                n_stepped++;
            end
        end
        r.ang_one = joint_one;
        r.ang_two = joint_two;
        expected_results.push_back(r);
    endtask

    // stream driver
    always @(posedge aclk) begin
        arm_cmd_t cmd;
        logic     holding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            holding = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_step(arm_cmd_t'({s_tuser, s_tdata[15:0], s_tdata[31:16]}));
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cmd = pending_cmds.pop_front();
                    s_tdata <= {cmd.ang_two, cmd.ang_one};
                    s_tuser <= cmd.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        arm_result_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[15:0] !== e.ang_one) begin
                        $error("angle_one exp %0h got %0h", e.ang_one, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== e.ang_two) begin
                        $error("angle_two exp %0h got %0h", e.ang_two, m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tdata[51:32] !== e.pos_x) begin
                        $error("pos_x exp %0h got %0h", e.pos_x, m_tdata[51:32]);
                        errors++;
                    end
                    if (m_tdata[71:52] !== e.pos_y) begin
                        $error("pos_y exp %0h got %0h", e.pos_y, m_tdata[71:52]);
                        errors++;
                    end
                    if (m_tdata[91:72] !== e.err_dist) begin
                        $error("error_distance exp %0h got %0h", e.err_dist, m_tdata[91:72]);
                        errors++;
                    end
                    if (m_tuser !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic apb_write(input trrs_pkg::cfg_addr_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            trrs_pkg::REG_LINK_ONE: link_one = val[15:0];
            trrs_pkg::REG_LINK_TWO: link_two = val[15:0];
            trrs_pkg::REG_TARGET_X: tgt_x = val[19:0];
            trrs_pkg::REG_TARGET_Y: tgt_y = val[19:0];
            trrs_pkg::REG_GAIN:     gain = val[15:0];
            trrs_pkg::REG_DT:       dt = val[15:0];
            trrs_pkg::REG_REACH:    reach = val[18:0];
            trrs_pkg::REG_DET_MIN:  det_min = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] l1, l2, input int tx, ty,
                              input logic [15:0] g, t, input logic [18:0] rd,
                              input logic [15:0] dm);
        apb_write(trrs_pkg::REG_LINK_ONE, 32'(l1));
        apb_write(trrs_pkg::REG_LINK_TWO, 32'(l2));
        apb_write(trrs_pkg::REG_TARGET_X, 32'(tx) & 32'hFFFFF);
        apb_write(trrs_pkg::REG_TARGET_Y, 32'(ty) & 32'hFFFFF);
        apb_write(trrs_pkg::REG_GAIN, 32'(g));
        apb_write(trrs_pkg::REG_DT, 32'(t));
        apb_write(trrs_pkg::REG_REACH, 32'(rd));
        apb_write(trrs_pkg::REG_DET_MIN, 32'(dm));
    endtask

    task automatic queue_cmd(input logic act, input logic [15:0] a1, a2);
        pending_cmds.push_back('{act, a1, a2});
    endtask

    task automatic drain;
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int count;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under reset configuration
        queue_cmd(1'b1, 16'h0000, 16'h0000);
        queue_cmd(1'b0, 16'h0000, 16'h0000);
        queue_cmd(1'b1, 16'hFFFF, 16'hFFFF);
        queue_cmd(1'b0, 16'hFFFF, 16'hFFFF);
        queue_cmd(1'b1, 16'h0000, 16'h0000);
        queue_cmd(1'b0, 16'h4000, 16'h8000);
        queue_cmd(1'b1, 16'h5555, 16'hAAAA);
        queue_cmd(1'b0, 16'hAAAA, 16'h5555);
        queue_cmd(1'b1, 16'h0000, 16'h0000);
        queue_cmd(1'b0, 16'h2000, 16'h4000);
        repeat (6) queue_cmd(1'b1, 16'h0000, 16'h0000);
        drain();

        for (int set = 0; set < 6; set++) begin
            case (set / 2)
                0: begin send_idle = 13; recv_idle = 71; end
                1: begin send_idle = 71; recv_idle = 13; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            count = 240;
            case (set)
                0: set_config(16'd4096, 16'd4096, 5000, 3000, 16'h0800, 16'h1000,
                              19'd200, 16'd17);
                1: begin
                    set_config(16'hFFFF, 16'hFFFF, 524287, -524288, 16'hFFFF, 16'hFFFF,
                               19'h7FFFF, 16'hFFFF);
                    count = 60;
                end
                2: begin
                    set_config(16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000, 19'd0, 16'd0);
                    count = 60;
                end
                3: set_config(16'($urandom_range(8192, 1024)), 16'($urandom_range(8192, 1024)),
                              $urandom_range(24000) - 12000, $urandom_range(24000) - 12000,
                              16'($urandom), 16'($urandom), 19'($urandom_range(2000)),
                              16'($urandom));
                4: begin
                    set_config(16'hFFFF, 16'd3000, -524288, 524287, 16'hFFFF, 16'hFFFF,
                               19'd0, 16'd0);
                    count = 200;
                end
                default: begin
                    set_config(16'd6000, 16'd2000, -3000, -4000, 16'h1000, 16'h0800,
                               19'd50, 16'd200);
                    count = 300;
                end
            endcase
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(99) < 15)
                    queue_cmd(1'b0, 16'($urandom), 16'($urandom));
                else
                    queue_cmd(1'b1, 16'($urandom), 16'($urandom));
            end
            drain();
        end

        repeat (300) @(posedge aclk);
        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("covered %0d loads, %0d moving steps, %0d reached, %0d singular",
                 n_loaded, n_stepped, n_reached, n_singular);
        $display("over seven register settings and three handshake pacing phases");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
